// File: sv/tilt_compensated_compass_heading_unit_macros.svh
// assertion macros used by the checker file
`ifndef TILT_COMPENSATED_COMPASS_HEADING_UNIT_MACROS_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_UNIT_MACROS_SVH

// same-cycle implication, switched off while reset is low
`define TCCH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define TCCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tcch_pkg.sv
// shared types, constants and helper functions of the compass heading unit
package tcch_pkg;

  localparam int AVG_LOG2_DEF     = 3;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int JOB_DEPTH_DEF    = 2;

  localparam int SAMPLE_W  = 16;
  localparam int ACC_AVG_W = 12;
  localparam int VEC_W     = 22;
  localparam int PROD_W    = 2 * VEC_W;
  localparam int DIV_NW    = 46;
  localparam int DIV_DW    = 32;
  localparam int SAT_IN_W  = 48;

  // item kinds
  localparam logic [1:0] KIND_ACCEL   = 2'd0;
  localparam logic [1:0] KIND_MAG     = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] BOUND_MIN_RST = 16'sd100;
  localparam logic signed [SAMPLE_W-1:0] BOUND_MAX_RST = -16'sd100;

  // one completed mag average with everything needed to finish it
  typedef struct packed {
    logic [2:0][SAMPLE_W-1:0]  avg;
    logic [2:0][SAMPLE_W-1:0]  mn;
    logic [2:0][SAMPLE_W-1:0]  mx;
    logic [2:0][ACC_AVG_W-1:0] acc;
  } tcch_job_t;

  // clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [SAT_IN_W-1:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

  // atan(2^-i) in degrees, q16
  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    logic [21:0] r;
    case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/tcch_front.sv
// front end: sample averaging, calibration bounds and job issue
module tcch_front import tcch_pkg::*; #(
  parameter int AVG_LOG2 = AVG_LOG2_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample_x,
  input  logic signed [SAMPLE_W-1:0] in_sample_y,
  input  logic signed [SAMPLE_W-1:0] in_sample_z,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic                       q_full,
  output logic                       q_push,
  output tcch_job_t                  q_job
);

  localparam int CNT_W = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
  localparam int AS_W  = ACC_AVG_W + AVG_LOG2;
  localparam int MS_W  = SAMPLE_W + AVG_LOG2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << AVG_LOG2) - 1);

  logic signed [SAMPLE_W-1:0]  smp [3];
  logic signed [AS_W-1:0]      asum_r [3];
  logic signed [AS_W-1:0]      asum_nxt [3];
  logic signed [MS_W-1:0]      msum_r [3];
  logic signed [MS_W-1:0]      msum_nxt [3];
  logic signed [ACC_AVG_W-1:0] aavg_r [3];
  logic signed [ACC_AVG_W-1:0] aavg_new [3];
  logic signed [SAMPLE_W-1:0]  mavg_new [3];
  logic signed [SAMPLE_W-1:0]  mn_r [3];
  logic signed [SAMPLE_W-1:0]  mx_r [3];
  logic [CNT_W-1:0]            acnt_r;
  logic [CNT_W-1:0]            mcnt_r;
  logic                        cal_r;
  logic                        accept;
  logic                        a_last;
  logic                        m_last;

  // divide by 16 toward zero
  function automatic logic signed [ACC_AVG_W-1:0] div16(input logic signed [15:0] s);
    logic signed [16:0] t;
    t = 17'(s) + (s[15] ? 17'sd15 : 17'sd0);
    return ACC_AVG_W'(t >>> 4);
  endfunction

  assign smp[0] = in_sample_x;
  assign smp[1] = in_sample_y;
  assign smp[2] = in_sample_z;
  assign full   = q_full;
  assign accept = push && !full;
  assign a_last = (acnt_r == CNT_LAST);
  assign m_last = (mcnt_r == CNT_LAST);

  // running sums and the averages they complete
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      asum_nxt[i] = asum_r[i] + AS_W'(div16(smp[i]));
      msum_nxt[i] = msum_r[i] + MS_W'(smp[i]);
      aavg_new[i] = ACC_AVG_W'(asum_nxt[i] >>> AVG_LOG2);
      mavg_new[i] = SAMPLE_W'(msum_nxt[i] >>> AVG_LOG2);
    end
  end

  // job towards the back end
  assign q_push = accept && (in_kind == KIND_MAG) && m_last && !cal_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_job.avg[i] = mavg_new[i];
      q_job.mn[i]  = mn_r[i];
      q_job.mx[i]  = mx_r[i];
      q_job.acc[i] = aavg_r[i];
    end
  end

  // item handling and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r  <= 1'b0;
      acnt_r <= '0;
      mcnt_r <= '0;
      for (int i = 0; i < 3; i++) begin
        asum_r[i] <= '0;
        msum_r[i] <= '0;
        aavg_r[i] <= '0;
        mn_r[i]   <= BOUND_MIN_RST;
        mx_r[i]   <= BOUND_MAX_RST;
      end
    end else begin
      if (cfg_we) cal_r <= cfg_wdata;
      if (accept) begin
        unique case (in_kind)
          KIND_ACCEL: begin
            if (a_last) begin
              acnt_r <= '0;
              for (int i = 0; i < 3; i++) begin
                asum_r[i] <= '0;
                aavg_r[i] <= aavg_new[i];
              end
            end else begin
              acnt_r <= CNT_W'(acnt_r + 1'b1);
              for (int i = 0; i < 3; i++) asum_r[i] <= asum_nxt[i];
            end
          end
          KIND_MAG: begin
            if (m_last) begin
              mcnt_r <= '0;
              for (int i = 0; i < 3; i++) begin
                msum_r[i] <= '0;
                if (cal_r) begin
                  if (mavg_new[i] >= mx_r[i]) mx_r[i] <= mavg_new[i];
                  if (mavg_new[i] <= mn_r[i]) mn_r[i] <= mavg_new[i];
                end
              end
            end else begin
              mcnt_r <= CNT_W'(mcnt_r + 1'b1);
              for (int i = 0; i < 3; i++) msum_r[i] <= msum_nxt[i];
            end
          end
          KIND_RESTART: begin
            for (int i = 0; i < 3; i++) begin
              mn_r[i] <= BOUND_MIN_RST;
              mx_r[i] <= BOUND_MAX_RST;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: sv/tcch_fifo.sv
// short job queue between front and back end
module tcch_fifo import tcch_pkg::*; #(
  parameter int DEPTH = JOB_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  tcch_job_t din,
  output logic      full,
  input  logic      rd,
  output tcch_job_t dout,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  tcch_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= din;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == PTR_LAST) ? '0 : PTR_W'(wp_r + 1'b1);
      if (do_rd) rp_r <= (rp_r == PTR_LAST) ? '0 : PTR_W'(rp_r + 1'b1);
      if (do_wr && !do_rd) cnt_r <= CNT_W'(cnt_r + 1'b1);
      else if (do_rd && !do_wr) cnt_r <= CNT_W'(cnt_r - 1'b1);
    end
  end

endmodule

// File: sv/tcch_div.sv
// bit-serial signed divider, quotient truncated toward zero
module tcch_div import tcch_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic signed [NW:0] num,
  input  logic signed [DW:0] den,
  output logic              done,
  output logic signed [NW:0] quo
);

  localparam int CW = $clog2(NW + 2);

  logic          busy_r;
  logic          done_r;
  logic          neg_r;
  logic [NW:0]   q_r;
  logic [DW:0]   d_r;
  logic [DW:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic [DW+1:0] trial;
  logic          ge;

  // one quotient bit per cycle
  assign trial = {rem_r, q_r[NW]};
  assign ge    = (trial >= {1'b0, d_r});
  assign done  = done_r;
  assign quo   = neg_r ? -$signed(q_r) : $signed(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW + 1);
        rem_r  <= '0;
        neg_r  <= num[NW] ^ den[DW];
        q_r    <= num[NW] ? (NW+1)'(-num) : (NW+1)'(num);
        d_r    <= den[DW] ? (DW+1)'(-den) : (DW+1)'(den);
      end else if (busy_r) begin
        rem_r <= ge ? (DW+1)'(trial - {1'b0, d_r}) : trial[DW:0];
        q_r   <= {q_r[NW-1:0], ge};
        cnt_r <= CW'(cnt_r - 1'b1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/tcch_back.sv
// back end: sequencer for scaling, cross products, normalising and atan2
module tcch_back import tcch_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  tcch_job_t  q_job,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [8:0] out_heading_deg,
  output logic [1:0] out_status
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_RANGE      = 4'd1;
  localparam logic [3:0] S_MDIV_GO    = 4'd2;
  localparam logic [3:0] S_MDIV_WAIT  = 4'd3;
  localparam logic [3:0] S_USQ        = 4'd4;
  localparam logic [3:0] S_USQRT      = 4'd5;
  localparam logic [3:0] S_UDIV_GO    = 4'd6;
  localparam logic [3:0] S_UDIV_WAIT  = 4'd7;
  localparam logic [3:0] S_CROSS      = 4'd8;
  localparam logic [3:0] S_ATAN_SETUP = 4'd9;
  localparam logic [3:0] S_CORDIC     = 4'd10;
  localparam logic [3:0] S_HEAD       = 4'd11;
  localparam logic [3:0] S_DONE       = 4'd12;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_N = 2'd1;
  localparam logic [1:0] PH_E = 2'd2;

  localparam int CW = 20;
  localparam int ZW = 26;

  logic [3:0]               state_r;
  tcch_job_t                job_r;
  logic signed [15:0]       m_r [3];
  logic signed [15:0]       a_r [3];
  logic signed [VEC_W-1:0]  e_r [3];
  logic signed [VEC_W-1:0]  n_r [3];
  logic signed [15:0]       ny_r;
  logic signed [15:0]       ey_r;
  logic [1:0]               idx_r;
  logic [2:0]               cnt_r;
  logic [1:0]               phase_r;
  logic                     xsel_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] first_r;
  logic [PROD_W+1:0]        ssum_r;
  logic [63:0]              sq_v_r;
  logic [63:0]              sq_root_r;
  logic [4:0]               sq_bi_r;
  logic [31:0]              len_r;
  logic [1:0]               status_r;
  logic [8:0]               heading_r;
  logic signed [CW-1:0]     cx_r;
  logic signed [CW-1:0]     cy_r;
  logic signed [ZW-1:0]     cz_r;
  logic [4:0]               it_r;
  logic                     res_valid_r;
  logic [8:0]               res_heading_r;
  logic [1:0]               res_status_r;

  logic signed [16:0]       rng [3];
  logic                     rng_zero;
  logic signed [VEC_W-1:0]  uv [3];
  logic signed [VEC_W-1:0]  pv [3];
  logic signed [VEC_W-1:0]  qv [3];
  logic [1:0]               uidx;
  logic [1:0]               pi;
  logic [1:0]               qi;
  logic signed [VEC_W-1:0]  ma;
  logic signed [VEC_W-1:0]  mb;
  logic [PROD_W+1:0]        ssum_fin;
  logic [63:0]              sq_b;
  logic [63:0]              sq_t;
  logic                     sq_ge;
  logic [63:0]              sq_root_nxt;
  logic [63:0]              sq_v_nxt;
  logic signed [PROD_W:0]   xd;
  logic signed [VEC_W-1:0]  xv;
  logic [1:0]               ci;
  logic signed [16:0]       mdiff;
  logic                     div_start;
  logic signed [DIV_NW:0]   div_num;
  logic signed [DIV_DW:0]   div_den;
  logic                     div_done;
  logic signed [DIV_NW:0]   div_quo;
  logic signed [15:0]       div_sat;
  logic signed [15:0]       m_sat;
  logic signed [CW-1:0]     cdx;
  logic signed [CW-1:0]     cdy;
  logic signed [ZW:0]       zr;
  logic signed [10:0]       hc;
  logic signed [10:0]       hw;
  logic                     res_load;

  assign empty           = !res_valid_r;
  assign out_heading_deg = res_heading_r;
  assign out_status      = res_status_r;
  assign q_pop           = (state_r == S_IDLE) && !q_empty;

  // bound ranges of the current job
  always_comb begin
    for (int i = 0; i < 3; i++)
      rng[i] = 17'($signed(job_r.mx[i])) - 17'($signed(job_r.mn[i]));
  end
  assign rng_zero = (rng[0] == '0) || (rng[1] == '0) || (rng[2] == '0);

  // vector under normalisation and cross product operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (phase_r)
        PH_N:    uv[i] = n_r[i];
        PH_E:    uv[i] = e_r[i];
        default: uv[i] = VEC_W'($signed(job_r.acc[i]));
      endcase
      pv[i] = xsel_r ? VEC_W'(a_r[i]) : VEC_W'(m_r[i]);
      qv[i] = xsel_r ? e_r[i] : VEC_W'(a_r[i]);
    end
  end

  assign uidx = (cnt_r < 3'd3) ? cnt_r[1:0] : 2'd0;

  // operand order of the six cross product terms
  always_comb begin
    case (cnt_r)
      3'd0:    begin pi = 2'd1; qi = 2'd2; end
      3'd1:    begin pi = 2'd2; qi = 2'd1; end
      3'd2:    begin pi = 2'd2; qi = 2'd0; end
      3'd3:    begin pi = 2'd0; qi = 2'd2; end
      3'd4:    begin pi = 2'd0; qi = 2'd1; end
      3'd5:    begin pi = 2'd1; qi = 2'd0; end
      default: begin pi = 2'd0; qi = 2'd0; end
    endcase
  end

  // shared multiplier operands
  always_comb begin
    if (state_r == S_CROSS) begin
      ma = pv[pi];
      mb = qv[qi];
    end else begin
      ma = uv[uidx];
      mb = uv[uidx];
    end
  end

  assign ssum_fin = ssum_r + (PROD_W+2)'(prod_r);

  // one square-root digit
  assign sq_b        = 64'd1 << {sq_bi_r, 1'b0};
  assign sq_t        = sq_root_r + sq_b;
  assign sq_ge       = (sq_v_r >= sq_t);
  assign sq_root_nxt = sq_ge ? ((sq_root_r >> 1) + sq_b) : (sq_root_r >> 1);
  assign sq_v_nxt    = sq_ge ? (sq_v_r - sq_t) : sq_v_r;

  // cross product term difference
  assign xd = (PROD_W+1)'(first_r) - (PROD_W+1)'(prod_r);
  assign xv = VEC_W'(xd >>> 14);
  assign ci = 2'(cnt_r[2:1] - 2'd1);

  // divider operands
  assign mdiff     = 17'($signed(job_r.avg[idx_r])) - 17'($signed(job_r.mn[idx_r]));
  assign div_start = (state_r == S_MDIV_GO) || (state_r == S_UDIV_GO);
  always_comb begin
    if (state_r == S_MDIV_GO) begin
      div_num = (DIV_NW+1)'(mdiff) <<< 15;
      div_den = (DIV_DW+1)'(rng[idx_r]);
    end else begin
      div_num = (DIV_NW+1)'(uv[idx_r]) <<< ((phase_r == PH_A) ? 28 : 24);
      div_den = {1'b0, len_r};
    end
  end
  assign div_sat = sat16(SAT_IN_W'(div_quo));
  assign m_sat   = sat16(SAT_IN_W'(div_quo) - 48'sd16384);

  tcch_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // cordic micro-rotation and heading rounding
  assign cdx = cy_r >>> it_r;
  assign cdy = cx_r >>> it_r;
  assign zr  = (ZW+1)'(cz_r) + 27'sd65535;
  assign hc  = 11'(zr >>> 16);
  assign hw  = (hc < 0) ? (hc + 11'sd360) : ((hc >= 11'sd360) ? (hc - 11'sd360) : hc);

  // result register, loaded when free or being transferred
  assign res_load = (state_r == S_DONE) && (!res_valid_r || pop);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r   <= 1'b1;
      res_heading_r <= heading_r;
      res_status_r  <= status_r;
    end else if (pop) begin
      res_valid_r <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            job_r   <= q_job;
            state_r <= S_RANGE;
          end
        end
        S_RANGE: begin
          idx_r <= 2'd0;
          if (rng_zero) begin
            status_r  <= STAT_RANGE;
            heading_r <= '0;
            state_r   <= S_DONE;
          end else begin
            state_r <= S_MDIV_GO;
          end
        end
        S_MDIV_GO: state_r <= S_MDIV_WAIT;
        S_MDIV_WAIT: begin
          if (div_done) begin
            m_r[idx_r] <= m_sat;
            if (idx_r == 2'd2) begin
              phase_r <= PH_A;
              cnt_r   <= 3'd0;
              state_r <= S_USQ;
            end else begin
              idx_r   <= 2'(idx_r + 1'b1);
              state_r <= S_MDIV_GO;
            end
          end
        end
        S_USQ: begin
          if (cnt_r < 3'd3) prod_r <= ma * mb;
          if (cnt_r == 3'd1) ssum_r <= (PROD_W+2)'(prod_r);
          else if (cnt_r == 3'd2) ssum_r <= ssum_fin;
          if (cnt_r == 3'd3) begin
            sq_v_r    <= 64'(ssum_fin) << ((phase_r == PH_A) ? 28 : 20);
            sq_root_r <= '0;
            sq_bi_r   <= 5'd31;
            state_r   <= S_USQRT;
          end else begin
            cnt_r <= 3'(cnt_r + 1'b1);
          end
        end
        S_USQRT: begin
          sq_v_r    <= sq_v_nxt;
          sq_root_r <= sq_root_nxt;
          sq_bi_r   <= 5'(sq_bi_r - 1'b1);
          if (sq_bi_r == 5'd0) begin
            len_r <= sq_root_nxt[31:0];
            idx_r <= (phase_r == PH_A) ? 2'd0 : 2'd1;
            if (sq_root_nxt == '0) begin
              status_r  <= STAT_ZERO;
              heading_r <= '0;
              state_r   <= S_DONE;
            end else begin
              state_r <= S_UDIV_GO;
            end
          end
        end
        S_UDIV_GO: state_r <= S_UDIV_WAIT;
        S_UDIV_WAIT: begin
          if (div_done) begin
            unique case (phase_r)
              PH_A: begin
                a_r[idx_r] <= div_sat;
                if (idx_r == 2'd2) begin
                  xsel_r  <= 1'b0;
                  cnt_r   <= 3'd0;
                  state_r <= S_CROSS;
                end else begin
                  idx_r   <= 2'(idx_r + 1'b1);
                  state_r <= S_UDIV_GO;
                end
              end
              PH_N: begin
                ny_r    <= div_sat;
                phase_r <= PH_E;
                cnt_r   <= 3'd0;
                state_r <= S_USQ;
              end
              default: begin
                ey_r    <= div_sat;
                state_r <= S_ATAN_SETUP;
              end
            endcase
          end
        end
        S_CROSS: begin
          if (cnt_r < 3'd6) prod_r <= ma * mb;
          if (cnt_r[0]) first_r <= prod_r;
          else if (cnt_r != 3'd0) begin
            if (xsel_r) n_r[ci] <= xv;
            else e_r[ci] <= xv;
          end
          if (cnt_r == 3'd6) begin
            cnt_r <= 3'd0;
            if (xsel_r) begin
              phase_r <= PH_N;
              state_r <= S_USQ;
            end else begin
              xsel_r <= 1'b1;
            end
          end else begin
            cnt_r <= 3'(cnt_r + 1'b1);
          end
        end
        S_ATAN_SETUP: begin
          it_r <= 5'd0;
          if (ey_r == 16'sd0) begin
            cz_r    <= (ny_r < 0) ? (ZW'(180) <<< 16) : '0;
            state_r <= S_HEAD;
          end else if (ny_r == 16'sd0) begin
            cz_r    <= (ey_r > 0) ? (ZW'(90) <<< 16) : -(ZW'(90) <<< 16);
            state_r <= S_HEAD;
          end else begin
            // fold the left half-plane onto the right by a quarter turn
            if (ny_r < 0 && ey_r > 0) begin
              cx_r <= CW'(ey_r);
              cy_r <= -CW'(ny_r);
              cz_r <= ZW'(90) <<< 16;
            end else if (ny_r < 0) begin
              cx_r <= -CW'(ey_r);
              cy_r <= CW'(ny_r);
              cz_r <= -(ZW'(90) <<< 16);
            end else begin
              cx_r <= CW'(ny_r);
              cy_r <= CW'(ey_r);
              cz_r <= '0;
            end
            state_r <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + cdx;
            cy_r <= cy_r - cdy;
            cz_r <= cz_r + ZW'(atan_q16(it_r));
          end else begin
            cx_r <= cx_r - cdx;
            cy_r <= cy_r + cdy;
            cz_r <= cz_r - ZW'(atan_q16(it_r));
          end
          it_r <= 5'(it_r + 1'b1);
          if (it_r == 5'(CORDIC_STEPS - 1)) state_r <= S_HEAD;
        end
        S_HEAD: begin
          heading_r <= (hw < 0) ? 9'd0 : hw[8:0];
          status_r  <= STAT_OK;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (res_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/tilt_compensated_compass_heading_unit.sv
// Tilt-compensated compass heading unit. The front end takes one sample per cycle while its
// job queue (JOB_DEPTH entries) has room; every 2^AVG_LOG2 magnetometer samples outside
// calibration make one job. The back end spends most of a job in a bit-serial divider
// (eight quotients per job) and a square root run three times, followed by one CORDIC
// step per cycle (exact-axis headings skip the CORDIC steps).
// The result waits in an output register until popped while the next job already runs.
// No clearing pass after reset is needed.
module tilt_compensated_compass_heading_unit import tcch_pkg::*; #(
  parameter int AVG_LOG2     = AVG_LOG2_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int JOB_DEPTH    = JOB_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample_x,
  input  logic signed [SAMPLE_W-1:0] in_sample_y,
  input  logic signed [SAMPLE_W-1:0] in_sample_z,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  output logic                       empty,
  input  logic                       pop,
  output logic [8:0]                 out_heading_deg,
  output logic [1:0]                 out_status
);

  logic      q_wr;
  logic      q_full;
  logic      q_rd;
  logic      q_empty;
  tcch_job_t q_din;
  tcch_job_t q_dout;

  // sample averaging and calibration
  tcch_front #(
    .AVG_LOG2 (AVG_LOG2)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_kind     (in_kind),
    .in_sample_x (in_sample_x),
    .in_sample_y (in_sample_y),
    .in_sample_z (in_sample_z),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_full      (q_full),
    .q_push      (q_wr),
    .q_job       (q_din)
  );

  // job queue
  tcch_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .din   (q_din),
    .full  (q_full),
    .rd    (q_rd),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // heading computation
  tcch_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (q_dout),
    .q_pop           (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_heading_deg (out_heading_deg),
    .out_status      (out_status)
  );

endmodule

// File: sv/tcch_checker.sv
// port-level checker for the compass heading unit and its bind
`include "tilt_compensated_compass_heading_unit_macros.svh"

module tcch_checker import tcch_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [8:0] out_heading_deg,
  input logic [1:0] out_status
);

  // a failed result carries no heading
  `TCCH_ASSERT_IMP(a_err_heading_zero, !empty && out_status != STAT_OK, out_heading_deg == 9'd0, "error result with nonzero heading")

  // headings stay within one turn
  `TCCH_ASSERT_IMP(a_heading_range, !empty, out_heading_deg < 9'd360, "heading out of range")

  // only defined status codes leave the block
  `TCCH_ASSERT_IMP(a_status_code, !empty, out_status == STAT_OK || out_status == STAT_RANGE || out_status == STAT_ZERO, "undefined status code")

  // reset leaves no result pending
  `TCCH_ASSERT_NEXT(a_reset_empty, !rst_n, empty, "result pending after reset")

  // a waiting result holds until transferred
  `TCCH_ASSERT_NEXT(a_result_hold, rst_n && !empty && !pop, !empty && $stable(out_heading_deg) && $stable(out_status), "waiting result changed")

endmodule

bind tilt_compensated_compass_heading_unit tcch_checker u_tcch_checker (.*);
